@@ rtl/core/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// Shader source tokenizer package
// Types, constants and helper functions shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package sst_pkg;

	localparam int MAX_SOURCE_BYTES = 1048576;
	localparam int POS_W = $clog2(MAX_SOURCE_BYTES + 1);
	localparam int OFF_W = 20;
	localparam int LEN_W = 21;
	localparam int LINE_W = 21;
	localparam int DEPTH_W = 20;
	localparam int CHAR_W = 8;
	localparam int CLS_W = 3;

	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_SOURCE_BYTES);
	localparam logic [LINE_W-1:0] LINE_SAT = {LINE_W{1'b1}};
	localparam logic [LINE_W-1:0] LINE_ONE = LINE_W'(1);
	localparam logic [LEN_W-1:0] LEN_SAT = {LEN_W{1'b1}};
	localparam logic [DEPTH_W-1:0] DEPTH_SAT = {DEPTH_W{1'b1}};
	localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

	localparam int NUM_SLOTS = 4;
	localparam int SEL_W = $clog2(NUM_SLOTS);
	localparam int FIFO_DEPTH = 2;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [CLS_W-1:0] CLS_IDENT = 3'd0;
	localparam logic [CLS_W-1:0] CLS_NUMBER = 3'd1;
	localparam logic [CLS_W-1:0] CLS_PUNCT = 3'd2;
	localparam logic [CLS_W-1:0] CLS_END = 3'd3;
	localparam logic [CLS_W-1:0] CLS_ERROR = 3'd4;

	localparam logic [CHAR_W-1:0] CH_NL = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
	localparam logic [CHAR_W-1:0] CH_VT = 8'h0B;
	localparam logic [CHAR_W-1:0] CH_FF = 8'h0C;
	localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_STAR = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_GT = 8'h3E;
	localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
	localparam logic [CHAR_W-1:0] CH_DOT = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_NUMBER,
		MODE_HSLASH,
		MODE_HMINUS,
		MODE_LINEC,
		MODE_BLOCKC
	} lex_mode_t;

	typedef struct packed {
		logic [CHAR_W-1:0] source_byte;
		logic              is_final;
	} src_item_t;

	typedef struct packed {
		logic [CLS_W-1:0]  token_class;
		logic [OFF_W-1:0]  start_offset;
		logic [LEN_W-1:0]  token_length;
		logic [LINE_W-1:0] line_number;
		logic [CHAR_W-1:0] first_char;
	} token_t;

	typedef struct packed {
		logic [CLS_W-1:0]  token_class;
		logic [OFF_W-1:0]  start_offset;
		logic [LEN_W-1:0]  token_length;
		logic [LINE_W-1:0] line_number;
		logic [CHAR_W-1:0] first_char;
		logic              run_end;
	} tok_item_t;

	typedef struct packed {
		token_t [NUM_SLOTS-1:0] slot;
		logic [NUM_SLOTS-1:0]   slot_vld;
	} bundle_t;

	function automatic logic is_letter(input logic [CHAR_W-1:0] b);
		return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
	endfunction

	function automatic logic is_numeral(input logic [CHAR_W-1:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic is_blank(input logic [CHAR_W-1:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_VT || b == CH_FF;
	endfunction

	function automatic logic [LINE_W-1:0] line_up(input logic [LINE_W-1:0] v);
		return (v < LINE_SAT) ? v + LINE_ONE : v;
	endfunction

	function automatic token_t mk_tok(
		input logic [CLS_W-1:0]  cls,
		input logic [POS_W-1:0]  start,
		input logic [POS_W-1:0]  len,
		input logic [LINE_W-1:0] line,
		input logic [CHAR_W-1:0] fc
	);
		token_t t;
		logic [POS_W+OFF_W-1:0] start_w;
		logic [POS_W+LEN_W-1:0] len_w;
		start_w = {{OFF_W{1'b0}}, start};
		len_w = {{LEN_W{1'b0}}, len};
		t.token_class = cls;
		t.start_offset = start_w[OFF_W-1:0];
		t.token_length = (len_w > {{POS_W{1'b0}}, LEN_SAT}) ? LEN_SAT : len_w[LEN_W-1:0];
		t.line_number = line;
		t.first_char = fc;
		return t;
	endfunction

endpackage

@@ rtl/core/sst_front.sv @@
// ----------------------------------------------------------------------------
// Tokenizer front end
// Holds the lexer state, classifies each source byte and forms the group of
// tokens that the byte completes.
// ----------------------------------------------------------------------------
module sst_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_ready,
	input  sst_pkg::src_item_t src_item,
	output logic               push,
	output sst_pkg::bundle_t   push_data,
	input  logic               full
);

	sst_pkg::lex_mode_t mode_q, mode_n;
	logic [sst_pkg::POS_W-1:0]   pos_q, pos_n;
	logic [sst_pkg::POS_W-1:0]   start_q, start_n;
	logic [sst_pkg::CHAR_W-1:0]  fc_q, fc_n;
	logic [sst_pkg::LINE_W-1:0]  line_q, line_n;
	logic [sst_pkg::DEPTH_W-1:0] depth_q, depth_n;
	logic [sst_pkg::LINE_W-1:0]  csl_q, csl_n;
	logic                        saw_slash_q, saw_slash_n;
	logic                        saw_star_q, saw_star_n;

	logic [sst_pkg::CHAR_W-1:0] b;
	logic [sst_pkg::POS_W-1:0]  off;
	logic [sst_pkg::POS_W-1:0]  nxt;
	logic                       fire;
	logic                       run_idle;
	logic                       cont;
	logic [sst_pkg::DEPTH_W-1:0] depth_dec;
	sst_pkg::bundle_t           bnd;

	assign src_ready = !full;
	assign fire = src_valid && src_ready;
	assign b = src_item.source_byte;
	assign off = pos_q;
	assign nxt = (pos_q < sst_pkg::POS_MAX) ? pos_q + sst_pkg::POS_W'(1) : sst_pkg::POS_MAX;
	assign depth_dec = (depth_q != '0) ? depth_q - sst_pkg::DEPTH_ONE : depth_q;

	always_comb begin
		mode_n = mode_q;
		pos_n = nxt;
		start_n = start_q;
		fc_n = fc_q;
		line_n = line_q;
		depth_n = depth_q;
		csl_n = csl_q;
		saw_slash_n = saw_slash_q;
		saw_star_n = saw_star_q;
		bnd = '0;
		run_idle = 1'b0;
		cont = 1'b0;

		case (mode_q)
			sst_pkg::MODE_IDENT, sst_pkg::MODE_NUMBER: begin
				if (mode_q == sst_pkg::MODE_IDENT) begin
					cont = sst_pkg::is_letter(b) || sst_pkg::is_numeral(b) ||
						b == sst_pkg::CH_UNDER;
				end else begin
					cont = sst_pkg::is_letter(b) || sst_pkg::is_numeral(b) ||
						b == sst_pkg::CH_DOT;
				end
				if (!cont) begin
					bnd.slot_vld[0] = 1'b1;
					bnd.slot[0] = sst_pkg::mk_tok(
						(mode_q == sst_pkg::MODE_IDENT) ? sst_pkg::CLS_IDENT : sst_pkg::CLS_NUMBER,
						start_q, off - start_q, line_q, fc_q);
					run_idle = 1'b1;
				end
			end
			sst_pkg::MODE_HSLASH: begin
				if (b == sst_pkg::CH_SLASH) begin
					mode_n = sst_pkg::MODE_LINEC;
				end else if (b == sst_pkg::CH_STAR) begin
					mode_n = sst_pkg::MODE_BLOCKC;
					depth_n = sst_pkg::DEPTH_ONE;
					csl_n = line_q;
					saw_slash_n = 1'b0;
					saw_star_n = 1'b0;
				end else begin
					bnd.slot_vld[0] = 1'b1;
					bnd.slot[0] = sst_pkg::mk_tok(sst_pkg::CLS_PUNCT, start_q,
						sst_pkg::POS_W'(1), line_q, sst_pkg::CH_SLASH);
					run_idle = 1'b1;
				end
			end
			sst_pkg::MODE_HMINUS: begin
				bnd.slot_vld[0] = 1'b1;
				if (b == sst_pkg::CH_GT) begin
					bnd.slot[0] = sst_pkg::mk_tok(sst_pkg::CLS_PUNCT, start_q,
						sst_pkg::POS_W'(2), line_q, sst_pkg::CH_MINUS);
					mode_n = sst_pkg::MODE_IDLE;
				end else begin
					bnd.slot[0] = sst_pkg::mk_tok(sst_pkg::CLS_PUNCT, start_q,
						sst_pkg::POS_W'(1), line_q, sst_pkg::CH_MINUS);
					run_idle = 1'b1;
				end
			end
			sst_pkg::MODE_LINEC: begin
				if (b == sst_pkg::CH_NL) begin
					line_n = sst_pkg::line_up(line_q);
					mode_n = sst_pkg::MODE_IDLE;
				end
			end
			sst_pkg::MODE_BLOCKC: begin
				if (saw_slash_q && b == sst_pkg::CH_STAR) begin
					if (depth_q < sst_pkg::DEPTH_SAT) begin
						depth_n = depth_q + sst_pkg::DEPTH_ONE;
					end
					saw_slash_n = 1'b0;
					saw_star_n = 1'b0;
				end else if (saw_star_q && b == sst_pkg::CH_SLASH) begin
					depth_n = depth_dec;
					saw_slash_n = 1'b0;
					saw_star_n = 1'b0;
					if (depth_dec == '0) begin
						mode_n = sst_pkg::MODE_IDLE;
					end
				end else begin
					if (b == sst_pkg::CH_NL) begin
						line_n = sst_pkg::line_up(line_q);
					end
					saw_slash_n = b == sst_pkg::CH_SLASH;
					saw_star_n = b == sst_pkg::CH_STAR;
				end
			end
			default: begin
				run_idle = 1'b1;
			end
		endcase

		if (run_idle) begin
			mode_n = sst_pkg::MODE_IDLE;
			if (b == sst_pkg::CH_NL) begin
				line_n = sst_pkg::line_up(line_q);
			end else if (sst_pkg::is_blank(b)) begin
				mode_n = sst_pkg::MODE_IDLE;
			end else if (b == sst_pkg::CH_SLASH) begin
				mode_n = sst_pkg::MODE_HSLASH;
				start_n = off;
			end else if (b == sst_pkg::CH_MINUS) begin
				mode_n = sst_pkg::MODE_HMINUS;
				start_n = off;
			end else if (sst_pkg::is_letter(b) || b == sst_pkg::CH_UNDER) begin
				mode_n = sst_pkg::MODE_IDENT;
				start_n = off;
				fc_n = b;
			end else if (sst_pkg::is_numeral(b)) begin
				mode_n = sst_pkg::MODE_NUMBER;
				start_n = off;
				fc_n = b;
			end else begin
				bnd.slot_vld[1] = 1'b1;
				bnd.slot[1] = sst_pkg::mk_tok(sst_pkg::CLS_PUNCT, off,
					sst_pkg::POS_W'(1), line_q, b);
			end
		end

		if (src_item.is_final) begin
			case (mode_n)
				sst_pkg::MODE_IDENT, sst_pkg::MODE_NUMBER: begin
					bnd.slot_vld[2] = 1'b1;
					bnd.slot[2] = sst_pkg::mk_tok(
						(mode_n == sst_pkg::MODE_IDENT) ? sst_pkg::CLS_IDENT : sst_pkg::CLS_NUMBER,
						start_n, nxt - start_n, line_n, fc_n);
				end
				sst_pkg::MODE_HSLASH: begin
					bnd.slot_vld[2] = 1'b1;
					bnd.slot[2] = sst_pkg::mk_tok(sst_pkg::CLS_PUNCT, start_n,
						sst_pkg::POS_W'(1), line_n, sst_pkg::CH_SLASH);
				end
				sst_pkg::MODE_HMINUS: begin
					bnd.slot_vld[2] = 1'b1;
					bnd.slot[2] = sst_pkg::mk_tok(sst_pkg::CLS_PUNCT, start_n,
						sst_pkg::POS_W'(1), line_n, sst_pkg::CH_MINUS);
				end
				default: begin
					bnd.slot_vld[2] = 1'b0;
				end
			endcase
			bnd.slot_vld[3] = 1'b1;
			if (mode_n == sst_pkg::MODE_BLOCKC) begin
				bnd.slot[3] = sst_pkg::mk_tok(sst_pkg::CLS_ERROR, '0, '0, csl_n, sst_pkg::CH_NUL);
			end else begin
				bnd.slot[3] = sst_pkg::mk_tok(sst_pkg::CLS_END, '0, '0, line_n, sst_pkg::CH_NUL);
			end
			mode_n = sst_pkg::MODE_IDLE;
			pos_n = '0;
			start_n = '0;
			fc_n = '0;
			line_n = sst_pkg::LINE_ONE;
			depth_n = '0;
			csl_n = sst_pkg::LINE_ONE;
			saw_slash_n = 1'b0;
			saw_star_n = 1'b0;
		end
	end

	assign push = fire && (bnd.slot_vld != '0);
	assign push_data = bnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sst_pkg::MODE_IDLE;
			pos_q <= '0;
			start_q <= '0;
			fc_q <= '0;
			line_q <= sst_pkg::LINE_ONE;
			depth_q <= '0;
			csl_q <= sst_pkg::LINE_ONE;
			saw_slash_q <= 1'b0;
			saw_star_q <= 1'b0;
		end else if (fire) begin
			mode_q <= mode_n;
			pos_q <= pos_n;
			start_q <= start_n;
			fc_q <= fc_n;
			line_q <= line_n;
			depth_q <= depth_n;
			csl_q <= csl_n;
			saw_slash_q <= saw_slash_n;
			saw_star_q <= saw_star_n;
		end
	end

endmodule

@@ rtl/core/sst_fifo.sv @@
// ----------------------------------------------------------------------------
// Token group queue
// Short queue of token groups between the front end and the output stage.
// ----------------------------------------------------------------------------
module sst_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sst_pkg::bundle_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output sst_pkg::bundle_t head
);

	sst_pkg::bundle_t            entry_q [sst_pkg::FIFO_DEPTH];
	logic [sst_pkg::PTR_W-1:0]   wr_ptr_q;
	logic [sst_pkg::PTR_W-1:0]   rd_ptr_q;
	logic [sst_pkg::CNT_W-1:0]   count_q;
	logic                        do_pop;

	assign full = count_q == sst_pkg::CNT_W'(sst_pkg::FIFO_DEPTH);
	assign head_valid = count_q != '0;
	assign head = entry_q[rd_ptr_q];
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + sst_pkg::PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + sst_pkg::PTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + sst_pkg::CNT_W'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - sst_pkg::CNT_W'(1);
			end
		end
	end

endmodule

@@ rtl/core/sst_back.sv @@
// ----------------------------------------------------------------------------
// Tokenizer output stage
// Takes the tokens of the queue head one at a time into the output register
// and marks the last token of each group.
// ----------------------------------------------------------------------------
module sst_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  sst_pkg::bundle_t   head,
	output logic               pop,
	output logic               tok_valid,
	input  logic               tok_ready,
	output sst_pkg::tok_item_t tok_item
);

	logic [sst_pkg::NUM_SLOTS-1:0] taken_q;
	logic [sst_pkg::NUM_SLOTS-1:0] remaining;
	logic [sst_pkg::NUM_SLOTS-1:0] sel_mask;
	logic [sst_pkg::SEL_W-1:0]     sel;
	logic                          last;
	logic                          load;
	logic                          out_valid_q;
	sst_pkg::tok_item_t            out_q;
	sst_pkg::token_t               pick;

	assign remaining = head.slot_vld & ~taken_q;

	always_comb begin
		sel = '0;
		for (int i = sst_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
			if (remaining[i]) begin
				sel = sst_pkg::SEL_W'(i);
			end
		end
	end

	assign sel_mask = {{(sst_pkg::NUM_SLOTS-1){1'b0}}, 1'b1} << sel;
	assign last = (remaining & ~sel_mask) == '0;
	assign pick = head.slot[sel];
	assign load = head_valid && (remaining != '0) && (!out_valid_q || tok_ready);
	assign pop = load && last;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.token_class <= pick.token_class;
			out_q.start_offset <= pick.start_offset;
			out_q.token_length <= pick.token_length;
			out_q.line_number <= pick.line_number;
			out_q.first_char <= pick.first_char;
			out_q.run_end <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				taken_q <= last ? '0 : (taken_q | sel_mask);
			end else if (tok_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign tok_valid = out_valid_q;
	assign tok_item = out_q;

endmodule

@@ rtl/core/shader_source_tokenizer_unit.sv @@
// ----------------------------------------------------------------------------
// Shader source tokenizer
// Splits a byte stream of shader source into identifier, number and
// punctuation tokens, drops blanks and comments, and closes each source with
// an end or error token.
// ----------------------------------------------------------------------------
// A byte's tokens pass through the token queue and then the output register.
// Throughput: one byte per cycle while src_ready is high; a byte's tokens
// leave the single-token output register one at a time, and the two-entry
// token queue drops src_ready when it fills.
// Reset: arst_n clears the lexer state to the start of a new source and
// empties the queue and the output register.
module shader_source_tokenizer_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_ready,
	input  sst_pkg::src_item_t src_item,
	output logic               tok_valid,
	input  logic               tok_ready,
	output sst_pkg::tok_item_t tok_item
);

	logic             push;
	logic             full;
	logic             pop;
	logic             head_valid;
	sst_pkg::bundle_t push_data;
	sst_pkg::bundle_t head;

	sst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_item  (src_item),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	sst_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	sst_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.tok_valid  (tok_valid),
		.tok_ready  (tok_ready),
		.tok_item   (tok_item)
	);

endmodule

@@ rtl/core/sst_checker.sv @@
// ----------------------------------------------------------------------------
// Tokenizer port checker
// Watches the ports of the tokenizer and flags token streams that cannot
// come from a correct design.
// ----------------------------------------------------------------------------
module sst_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               tok_valid,
	input logic               tok_ready,
	input sst_pkg::tok_item_t tok_item
);

	a_tok_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> tok_valid && $stable(tok_item))
	else $error("Token changed or dropped while stalled.");

	a_close_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (tok_item.token_class == sst_pkg::CLS_END ||
		tok_item.token_class == sst_pkg::CLS_ERROR) |-> tok_item.run_end)
	else $error("End or error token is not the last token of its byte.");

	a_close_fields: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (tok_item.token_class == sst_pkg::CLS_END ||
		tok_item.token_class == sst_pkg::CLS_ERROR) |->
		tok_item.token_length == '0 && tok_item.start_offset == '0 &&
		tok_item.first_char == sst_pkg::CH_NUL)
	else $error("End or error token carries offset, length or character.");

	a_punct_len: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_item.token_class == sst_pkg::CLS_PUNCT |->
		tok_item.token_length == sst_pkg::LEN_W'(1) ||
		tok_item.token_length == sst_pkg::LEN_W'(2))
	else $error("Punctuation token with a length other than one or two.");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !tok_valid)
	else $error("Token valid right after reset.");

endmodule

bind shader_source_tokenizer_unit sst_checker u_sst_checker (.*);
